>>> rtl/core/cste_pkg.sv
// Shared types and constants for the call stack exclusive-time profiler.
// No dependencies; imported by every module of the block.
`default_nettype none
package cste_pkg;

    // Fixed field widths of the request and result ports
    localparam int CMD_W      = 2;
    localparam int ID_W       = 4;
    localparam int IN_TIME_W  = 32;
    localparam int OUT_TIME_W = 32;
    localparam int STAT_W     = 2;

    // Default sizing handed down from the top level
    localparam int NUM_FUNCS_DEF   = 16;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int TIME_BITS_DEF   = 32;

    // Request queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP  = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVF = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNF = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_OVF,
        OP_UNF,
        OP_POP,
        OP_DUMP
    } t_op_kind;

    typedef struct packed {
        t_op_kind kind;
        logic     has_parent;
    } t_op_ctl;

    localparam int CTL_W = $bits(t_op_ctl);

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EMIT,
        BK_POP_SPAN,
        BK_POP_ADD,
        BK_POP_RDP,
        BK_POP_SUB,
        BK_DUMP_RD,
        BK_DUMP_OUT
    } t_back_state;

endpackage
`default_nettype wire

>>> rtl/core/cste_front.sv
// Front end: accepts requests, folds the function ID, tracks the stack level
// and classifies each request into an operation for the back end. Uses cste_pkg.
`default_nettype none
module cste_front #(
    parameter int NUM_FUNCS   = cste_pkg::NUM_FUNCS_DEF,
    parameter int STACK_DEPTH = cste_pkg::STACK_DEPTH_DEF,
    parameter int TIME_BITS   = cste_pkg::TIME_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic [cste_pkg::CMD_W-1:0]           i_command,
    input  wire logic [cste_pkg::ID_W-1:0]            i_func_id,
    input  wire logic [cste_pkg::IN_TIME_W-1:0]       i_timestamp,
    input  wire logic                                 i_q_full,
    output logic                                      o_push,
    output cste_pkg::t_op_ctl                         o_ctl,
    output logic [cste_pkg::ID_W-1:0]                 o_id,
    output logic [((TIME_BITS < 32) ? TIME_BITS : 32)-1:0] o_time,
    output logic [$clog2(STACK_DEPTH)-1:0]            o_idx
);
    import cste_pkg::*;

    localparam int SW     = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam int SIDX_W = $clog2(STACK_DEPTH);
    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int ID_N   = 1 << ID_W;

    logic [LVL_W-1:0] r_level;
    logic [LVL_W-1:0] n_level;
    logic [ID_W-1:0]  id_lut [ID_N];
    logic             accept;

    // ID folding table, fixed at elaboration
    for (genvar g = 0; g < ID_N; g++) begin : g_id_lut
        assign id_lut[g] = ID_W'(g % NUM_FUNCS);
    end

    assign accept = i_start && !i_q_full;
    assign o_id   = id_lut[i_func_id];
    assign o_time = i_timestamp[SW-1:0];

    always_comb begin
        n_level         = r_level;
        o_push          = 1'b0;
        o_ctl.kind      = OP_PUSH;
        o_ctl.has_parent = 1'b0;
        o_idx           = r_level[SIDX_W-1:0];
        case (i_command)
            CMD_START: begin
                o_push = accept;
                if (r_level == LVL_W'(STACK_DEPTH)) begin
                    o_ctl.kind = OP_OVF;
                end else begin
                    o_ctl.kind = OP_PUSH;
                    if (accept) begin
                        n_level = r_level + 1'b1;
                    end
                end
            end
            CMD_END: begin
                o_push = accept;
                if (r_level == '0) begin
                    o_ctl.kind = OP_UNF;
                end else begin
                    o_ctl.kind       = OP_POP;
                    o_ctl.has_parent = (r_level > LVL_W'(1));
                    o_idx            = SIDX_W'(r_level - 1'b1);
                    if (accept) begin
                        n_level = r_level - 1'b1;
                    end
                end
            end
            CMD_DUMP: begin
                o_push     = accept;
                o_ctl.kind = OP_DUMP;
                if (accept) begin
                    n_level = '0;
                end
            end
            default: begin
                // drop unknown commands
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/cste_queue.sv
// Two-entry request queue between front and back end.
// Uses cste_pkg for its depth.
`default_nettype none
module cste_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_rdata
);
    import cste_pkg::*;

    logic [DATA_W-1:0]  r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/cste_back.sv
// Back end: executes queued operations against the call stack memory and the
// totals memory, and drives the registered result ports. Uses cste_pkg.
`default_nettype none
module cste_back #(
    parameter int NUM_FUNCS   = cste_pkg::NUM_FUNCS_DEF,
    parameter int STACK_DEPTH = cste_pkg::STACK_DEPTH_DEF,
    parameter int TIME_BITS   = cste_pkg::TIME_BITS_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_q_valid,
    input  wire cste_pkg::t_op_ctl                         i_ctl,
    input  wire logic [cste_pkg::ID_W-1:0]                 i_id,
    input  wire logic [((TIME_BITS < 32) ? TIME_BITS : 32)-1:0] i_time,
    input  wire logic [$clog2(STACK_DEPTH)-1:0]            i_idx,
    output logic                                           o_q_pop,
    output logic                                           o_result_valid,
    output logic [cste_pkg::ID_W-1:0]                      o_result_id,
    output logic [cste_pkg::OUT_TIME_W-1:0]                o_exclusive_time,
    output logic [cste_pkg::STAT_W-1:0]                    o_status,
    output logic                                           o_last
);
    import cste_pkg::*;

    localparam int SW     = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam int SIDX_W = $clog2(STACK_DEPTH);
    localparam int TIDX_W = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
    localparam int ST_W   = ID_W + SW;
    localparam logic [TIDX_W-1:0] K_LAST = TIDX_W'(NUM_FUNCS - 1);

    // call stack memory, contents undefined until pushed
    logic [ST_W-1:0]       r_stack [STACK_DEPTH];
    logic [ST_W-1:0]       r_st_rd;
    logic                  st_we;
    logic [SIDX_W-1:0]     st_waddr;
    logic [ST_W-1:0]       st_wdata;
    logic [SIDX_W-1:0]     st_raddr;

    // totals memory with per-entry valid bits; an invalid entry reads as zero
    logic [OUT_TIME_W-1:0] r_tot [NUM_FUNCS];
    logic [NUM_FUNCS-1:0]  r_tot_vld;
    logic [OUT_TIME_W-1:0] r_tot_rd;
    logic [TIDX_W-1:0]     tot_raddr;
    logic                  tot_we;
    logic [TIDX_W-1:0]     tot_waddr;
    logic [OUT_TIME_W-1:0] tot_wdata;
    logic                  tot_clr;

    t_back_state           r_state, n_state;
    logic [ID_W-1:0]       r_id, n_id;
    logic [SW-1:0]         r_time, n_time;
    logic [SIDX_W-1:0]     r_idx, n_idx;
    logic                  r_has_par, n_has_par;
    logic [STAT_W-1:0]     r_status, n_status;
    logic [OUT_TIME_W-1:0] r_span, n_span;
    logic [OUT_TIME_W-1:0] r_sum, n_sum;
    logic [ID_W-1:0]       r_par_id, n_par_id;
    logic [TIDX_W-1:0]     r_k, n_k;

    logic                  r_o_valid, n_o_valid;
    logic [ID_W-1:0]       r_o_id, n_o_id;
    logic [OUT_TIME_W-1:0] r_o_time, n_o_time;
    logic [STAT_W-1:0]     r_o_status, n_o_status;
    logic                  r_o_last, n_o_last;

    assign o_result_valid   = r_o_valid;
    assign o_result_id      = r_o_id;
    assign o_exclusive_time = r_o_time;
    assign o_status         = r_o_status;
    assign o_last           = r_o_last;

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_stack[st_waddr] <= st_wdata;
        end
        r_st_rd <= r_stack[st_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tot_we) begin
            r_tot[tot_waddr] <= tot_wdata;
        end
        r_tot_rd <= r_tot_vld[tot_raddr] ? r_tot[tot_raddr] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_vld <= '0;
        end else if (tot_clr) begin
            r_tot_vld <= '0;
        end else if (tot_we) begin
            r_tot_vld[tot_waddr] <= 1'b1;
        end
    end

    always_comb begin
        logic [OUT_TIME_W-1:0] sum;
        logic [OUT_TIME_W-1:0] diff;
        sum        = r_tot_rd + r_span;
        diff       = r_tot_rd - r_span;
        n_state    = r_state;
        n_id       = r_id;
        n_time     = r_time;
        n_idx      = r_idx;
        n_has_par  = r_has_par;
        n_status   = r_status;
        n_span     = r_span;
        n_sum      = r_sum;
        n_par_id   = r_par_id;
        n_k        = r_k;
        n_o_valid  = 1'b0;
        n_o_id     = r_o_id;
        n_o_time   = r_o_time;
        n_o_status = r_o_status;
        n_o_last   = r_o_last;
        o_q_pop    = 1'b0;
        st_we      = 1'b0;
        st_waddr   = i_idx;
        st_wdata   = {i_id, i_time};
        st_raddr   = r_idx;
        tot_raddr  = TIDX_W'(r_id);
        tot_we     = 1'b0;
        tot_waddr  = TIDX_W'(r_id);
        tot_wdata  = sum;
        tot_clr    = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_id      = i_id;
                    n_time    = i_time;
                    n_idx     = i_idx;
                    n_has_par = i_ctl.has_parent;
                    case (i_ctl.kind)
                        OP_PUSH: begin
                            st_we     = 1'b1;
                            tot_raddr = TIDX_W'(i_id);
                            n_status  = STAT_OK;
                            n_state   = BK_EMIT;
                        end
                        OP_OVF: begin
                            tot_raddr = TIDX_W'(i_id);
                            n_status  = STAT_OVF;
                            n_state   = BK_EMIT;
                        end
                        OP_UNF: begin
                            n_o_valid  = 1'b1;
                            n_o_id     = '0;
                            n_o_time   = '0;
                            n_o_status = STAT_UNF;
                            n_o_last   = 1'b1;
                        end
                        OP_POP: begin
                            st_raddr = i_idx;
                            n_state  = BK_POP_SPAN;
                        end
                        OP_DUMP: begin
                            n_k     = '0;
                            n_state = BK_DUMP_RD;
                        end
                        default: begin
                            n_state = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_EMIT: begin
                n_o_valid  = 1'b1;
                n_o_id     = r_id;
                n_o_time   = r_tot_rd;
                n_o_status = r_status;
                n_o_last   = 1'b1;
                n_state    = BK_IDLE;
            end
            BK_POP_SPAN: begin
                // span covers both end units: end - start + 1
                n_id      = r_st_rd[ST_W-1 -: ID_W];
                n_span    = OUT_TIME_W'(r_time) - OUT_TIME_W'(r_st_rd[SW-1:0])
                            + OUT_TIME_W'(1);
                tot_raddr = TIDX_W'(r_st_rd[ST_W-1 -: ID_W]);
                st_raddr  = r_idx - 1'b1;
                n_state   = BK_POP_ADD;
            end
            BK_POP_ADD: begin
                tot_we    = 1'b1;
                tot_waddr = TIDX_W'(r_id);
                tot_wdata = sum;
                n_sum     = sum;
                n_par_id  = r_st_rd[ST_W-1 -: ID_W];
                if (r_has_par) begin
                    n_state = BK_POP_RDP;
                end else begin
                    n_o_valid  = 1'b1;
                    n_o_id     = r_id;
                    n_o_time   = sum;
                    n_o_status = STAT_OK;
                    n_o_last   = 1'b1;
                    n_state    = BK_IDLE;
                end
            end
            BK_POP_RDP: begin
                tot_raddr = TIDX_W'(r_par_id);
                n_state   = BK_POP_SUB;
            end
            BK_POP_SUB: begin
                tot_we     = 1'b1;
                tot_waddr  = TIDX_W'(r_par_id);
                tot_wdata  = diff;
                n_o_valid  = 1'b1;
                n_o_id     = r_id;
                // recursion: the caller is the same function, report after subtract
                n_o_time   = (r_par_id == r_id) ? diff : r_sum;
                n_o_status = STAT_OK;
                n_o_last   = 1'b1;
                n_state    = BK_IDLE;
            end
            BK_DUMP_RD: begin
                tot_raddr = r_k;
                n_state   = BK_DUMP_OUT;
            end
            BK_DUMP_OUT: begin
                n_o_valid  = 1'b1;
                n_o_id     = ID_W'(r_k);
                n_o_time   = r_tot_rd;
                n_o_status = STAT_OK;
                n_o_last   = (r_k == K_LAST);
                if (r_k == K_LAST) begin
                    tot_clr = 1'b1;
                    n_state = BK_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = BK_DUMP_RD;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id       <= n_id;
        r_time     <= n_time;
        r_idx      <= n_idx;
        r_has_par  <= n_has_par;
        r_status   <= n_status;
        r_span     <= n_span;
        r_sum      <= n_sum;
        r_par_id   <= n_par_id;
        r_k        <= n_k;
        r_o_id     <= n_o_id;
        r_o_time   <= n_o_time;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
    end

endmodule
`default_nettype wire

>>> rtl/core/call_stack_exclusive_time.sv
// The back end takes one request at a time from the queue and finishes it before the next:
// a start pushes onto the stack and emits its total; an end on an empty stack reports underflow;
// an end adds its span to its total and, with a caller, subtracts it from the caller's total;
// a dump emits every total. A two-entry queue decouples it; busy rises only while it is full.
// Reset (synchronous, active low) empties stack level, queue and totals valid bits at once;
// stack contents are not cleared. The receiver cannot stall: each result shows one cycle.
`default_nettype none
module call_stack_exclusive_time #(
    parameter int NUM_FUNCS   = cste_pkg::NUM_FUNCS_DEF,
    parameter int STACK_DEPTH = cste_pkg::STACK_DEPTH_DEF,
    parameter int TIME_BITS   = cste_pkg::TIME_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [cste_pkg::CMD_W-1:0]      i_command,
    input  wire logic [cste_pkg::ID_W-1:0]       i_func_id,
    input  wire logic [cste_pkg::IN_TIME_W-1:0]  i_timestamp,
    output logic                                 o_result_valid,
    output logic [cste_pkg::ID_W-1:0]            o_result_id,
    output logic [cste_pkg::OUT_TIME_W-1:0]      o_exclusive_time,
    output logic [cste_pkg::STAT_W-1:0]          o_status,
    output logic                                 o_last
);
    import cste_pkg::*;

    // Stored start times keep at most 32 bits: the timestamp port is 32 bits wide
    localparam int SW     = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam int SIDX_W = $clog2(STACK_DEPTH);
    localparam int QW     = CTL_W + ID_W + SW + SIDX_W;

    // Front-end classification of the current request
    logic              f_push;
    t_op_ctl           f_ctl;
    logic [ID_W-1:0]   f_id;
    logic [SW-1:0]     f_time;
    logic [SIDX_W-1:0] f_idx;

    // Queue head as seen by the back end
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic [QW-1:0]     q_wdata;
    logic [QW-1:0]     q_rdata;
    t_op_ctl           b_ctl;
    logic [ID_W-1:0]   b_id;
    logic [SW-1:0]     b_time;
    logic [SIDX_W-1:0] b_idx;

    // Hold off new requests only while the queue has no free slot
    assign busy = q_full;

    // The front end owns the stack level, so overflow and underflow are decided
    // at acceptance and the back end only replays the resulting operations in order.
    cste_front #(
        .NUM_FUNCS   (NUM_FUNCS),
        .STACK_DEPTH (STACK_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_command   (i_command),
        .i_func_id   (i_func_id),
        .i_timestamp (i_timestamp),
        .i_q_full    (q_full),
        .o_push      (f_push),
        .o_ctl       (f_ctl),
        .o_id        (f_id),
        .o_time      (f_time),
        .o_idx       (f_idx)
    );

    // Pack each classified request into one queue word
    assign q_wdata = {f_ctl, f_id, f_time, f_idx};

    cste_queue #(
        .DATA_W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    // Unpack the queue head
    assign b_ctl  = t_op_ctl'(q_rdata[QW-1 -: CTL_W]);
    assign b_id   = q_rdata[SW+SIDX_W+ID_W-1 -: ID_W];
    assign b_time = q_rdata[SIDX_W+SW-1 -: SW];
    assign b_idx  = q_rdata[SIDX_W-1:0];

    // The back end runs the stack and totals memories one operation at a time
    cste_back #(
        .NUM_FUNCS   (NUM_FUNCS),
        .STACK_DEPTH (STACK_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_ctl            (b_ctl),
        .i_id             (b_id),
        .i_time           (b_time),
        .i_idx            (b_idx),
        .o_q_pop          (q_pop),
        .o_result_valid   (o_result_valid),
        .o_result_id      (o_result_id),
        .o_exclusive_time (o_exclusive_time),
        .o_status         (o_status),
        .o_last           (o_last)
    );

endmodule
`default_nettype wire

>>> rtl/core/cste_checker.sv
// Port-level checks for call_stack_exclusive_time, attached by bind.
// Uses cste_pkg for widths and status codes.
`default_nettype none
module cste_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            busy,
    input wire logic                            o_result_valid,
    input wire logic [cste_pkg::ID_W-1:0]       o_result_id,
    input wire logic [cste_pkg::OUT_TIME_W-1:0] o_exclusive_time,
    input wire logic [cste_pkg::STAT_W-1:0]     o_status,
    input wire logic                            o_last
);
    import cste_pkg::*;

    // Reset drops any pending result and frees the request port
    a_rst_no_result: assert property (@(posedge i_clk) !i_rst_n |=> !o_result_valid)
        else $error("result strobe right after reset");

    a_rst_not_busy: assert property (@(posedge i_clk) !i_rst_n |=> !busy)
        else $error("busy right after reset");

    // An underflow reports function 0 with a zero total
    a_unf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == STAT_UNF) |->
        (o_result_id == '0 && o_exclusive_time == '0))
        else $error("underflow result carries data");

    // Dropped requests produce a single, final result
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != STAT_OK) |-> o_last)
        else $error("error result not marked last");

endmodule

bind call_stack_exclusive_time cste_checker u_cste_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .busy             (busy),
    .o_result_valid   (o_result_valid),
    .o_result_id      (o_result_id),
    .o_exclusive_time (o_exclusive_time),
    .o_status         (o_status),
    .o_last           (o_last)
);
`default_nettype wire
